// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wth_pkg.sv -----
// Package: constants, CORDIC angle table and status codes for the wind triangle solver
`timescale 1ns / 1ps
package wth_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int XW = 36;
  localparam int ZW = 34;
  localparam int SQ = 32;
  localparam int LAT = 2 * NST + SQ + 5;
  localparam logic [29:0] INVK = 30'd652032874;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_KITE   = 2'd1,
    ST_LOW    = 2'd2
  } status_t;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };
endpackage

// ----- src/wth_course.sv -----
// Pipelined wind triangle solution for one course: CORDIC, square root, CORDIC
`timescale 1ns / 1ps
module wth_course (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           w,
  input  logic [15:0]           a,
  input  logic [15:0]           wd,
  input  logic [15:0]           crs,
  input  logic                  low,
  output logic [15:0]           hd,
  output logic signed [17:0]    gs,
  output wth_pkg::status_t      status
);
  localparam int N  = wth_pkg::NST;
  localparam int XW = wth_pkg::XW;
  localparam int ZW = wth_pkg::ZW;
  localparam int SQ = wth_pkg::SQ;

  // input fold and scaling
  logic [15:0]        d16;
  logic signed [16:0] ds;
  logic signed [16:0] dsf;
  logic               flip;
  logic [45:0]        prod;
  logic [45:0]        prod_r;
  logic signed [XW-1:0] x0u;

  always_comb begin
    d16 = wd - crs;
    ds = $signed({d16[15], d16});
    flip = 1'b0;
    dsf = ds;
    if (ds > 17'sd16384) begin
      dsf = ds - 17'sd32768;
      flip = 1'b1;
    end else if (ds < -17'sd16384) begin
      dsf = ds + 17'sd32768;
      flip = 1'b1;
    end
    prod = {30'd0, w} * {16'd0, wth_pkg::INVK};
    prod_r = (prod + 46'd8192) >> 14;
    x0u = $signed({4'd0, prod_r[31:0]});
  end

  // rotation CORDIC
  logic signed [XW-1:0] rx [0:N];
  logic signed [XW-1:0] ry [0:N];
  logic signed [ZW-1:0] rz [0:N];
  logic [15:0]          ra [0:N];
  logic [15:0]          rwd [0:N];
  logic [15:0]          rcrs [0:N];
  logic                 rlow [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= flip ? -x0u : x0u;
      ry[0] <= '0;
      rz[0] <= $signed({dsf[16], dsf, 16'd0});
      ra[0] <= a;
      rwd[0] <= wd;
      rcrs[0] <= crs;
      rlow[0] <= low;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [ZW-1:0] at;
    assign at = $signed({2'b00, wth_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!rz[i][ZW-1]) begin
          rx[i+1] <= rx[i] - (ry[i] >>> i);
          ry[i+1] <= ry[i] + (rx[i] >>> i);
          rz[i+1] <= rz[i] - at;
        end else begin
          rx[i+1] <= rx[i] + (ry[i] >>> i);
          ry[i+1] <= ry[i] - (rx[i] >>> i);
          rz[i+1] <= rz[i] + at;
        end
        ra[i+1] <= ra[i];
        rwd[i+1] <= rwd[i];
        rcrs[i+1] <= rcrs[i];
        rlow[i+1] <= rlow[i];
      end
    end
  end

  // squares and kite test
  logic [XW-1:0]        yabs;
  logic [31:0]          p1_a2;
  logic [63:0]          p1_y2;
  logic                 p1_kite;
  logic signed [XW-1:0] p1_x;
  logic signed [XW-1:0] p1_y;
  logic [15:0]          p1_wd;
  logic [15:0]          p1_crs;
  logic                 p1_low;

  assign yabs = ry[N][XW-1] ? $unsigned(-ry[N]) : $unsigned(ry[N]);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a2 <= {16'd0, ra[N]} * {16'd0, ra[N]};
      p1_y2 <= {32'd0, yabs[31:0]} * {32'd0, yabs[31:0]};
      p1_kite <= yabs > {4'd0, ra[N], 16'd0};
      p1_x <= rx[N];
      p1_y <= ry[N];
      p1_wd <= rwd[N];
      p1_crs <= rcrs[N];
      p1_low <= rlow[N];
    end
  end

  // square root, one result bit per stage
  logic [34:0]          s_rem [0:SQ];
  logic [31:0]          s_root [0:SQ];
  logic [63:0]          s_v [0:SQ];
  logic signed [XW-1:0] s_x [0:SQ];
  logic signed [XW-1:0] s_y [0:SQ];
  logic                 s_kite [0:SQ];
  logic [15:0]          s_wd [0:SQ];
  logic [15:0]          s_crs [0:SQ];
  logic                 s_low [0:SQ];

  always_ff @(posedge clk) begin
    if (en) begin
      s_v[0] <= {p1_a2, 32'd0} - p1_y2;
      s_rem[0] <= '0;
      s_root[0] <= '0;
      s_x[0] <= p1_x;
      s_y[0] <= p1_y;
      s_kite[0] <= p1_kite;
      s_wd[0] <= p1_wd;
      s_crs[0] <= p1_crs;
      s_low[0] <= p1_low;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [34:0] rem_n;
    logic [34:0] trial;
    logic        ge;
    assign rem_n = {s_rem[j][32:0], s_v[j][63:62]};
    assign trial = {1'b0, s_root[j], 2'b01};
    assign ge = rem_n >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[j+1] <= ge ? rem_n - trial : rem_n;
        s_root[j+1] <= {s_root[j][30:0], ge};
        s_v[j+1] <= {s_v[j][61:0], 2'b00};
        s_x[j+1] <= s_x[j];
        s_y[j+1] <= s_y[j];
        s_kite[j+1] <= s_kite[j];
        s_wd[j+1] <= s_wd[j];
        s_crs[j+1] <= s_crs[j];
        s_low[j+1] <= s_low[j];
      end
    end
  end

  // ground speed and vectoring CORDIC
  logic signed [37:0]   gsum;
  logic signed [21:0]   gsh;
  logic signed [17:0]   gsat;

  always_comb begin
    gsum = $signed({6'd0, s_root[SQ]}) - $signed({{2{s_x[SQ][XW-1]}}, s_x[SQ]})
           + 38'sd32768;
    gsh = gsum[37:16];
    if (gsh > 22'sd131071) begin
      gsat = 18'sd131071;
    end else if (gsh < -22'sd131072) begin
      gsat = -18'sd131072;
    end else begin
      gsat = gsh[17:0];
    end
  end

  logic signed [XW-1:0] vx [0:N];
  logic signed [XW-1:0] vy [0:N];
  logic signed [ZW-1:0] vz [0:N];
  logic signed [17:0]   vgs [0:N];
  logic                 vkite [0:N];
  logic [15:0]          vwd [0:N];
  logic [15:0]          vcrs [0:N];
  logic                 vlow [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= $signed({4'd0, s_root[SQ]});
      vy[0] <= s_y[SQ];
      vz[0] <= '0;
      vgs[0] <= gsat;
      vkite[0] <= s_kite[SQ];
      vwd[0] <= s_wd[SQ];
      vcrs[0] <= s_crs[SQ];
      vlow[0] <= s_low[SQ];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [ZW-1:0] at;
    assign at = $signed({2'b00, wth_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy[i][XW-1]) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + at;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - at;
        end
        vgs[i+1] <= vgs[i];
        vkite[i+1] <= vkite[i];
        vwd[i+1] <= vwd[i];
        vcrs[i+1] <= vcrs[i];
        vlow[i+1] <= vlow[i];
      end
    end
  end

  // result selection
  logic signed [ZW-1:0] zr;
  assign zr = vz[N] + 34'sd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vlow[N]) begin
        hd <= '0;
        gs <= '0;
        status <= wth_pkg::ST_LOW;
      end else if (vkite[N]) begin
        hd <= vwd[N] + wth_pkg::HALF_TURN;
        gs <= '0;
        status <= wth_pkg::ST_KITE;
      end else begin
        hd <= vcrs[N] + zr[31:16];
        gs <= vgs[N];
        status <= wth_pkg::ST_NORMAL;
      end
    end
  end
endmodule

// ----- src/wind_triangle_heading.sv -----
// Top level: wind triangle heading and ground speed solver for two courses
//
//   channel   signals                        direction
//   input     in_valid / in_ready + 5 fields into block
//   result    out_valid / out_ready + 5 flds out of block
//   config    cfg_we / cfg_data              into block
//
// One request per cycle while the pipeline is not held.
// Depth is set by the two CORDIC chains and the 32-step square root.
// The whole pipeline holds while a result waits and out_ready is low.
// Reset clears the valid bits and sets min_airspeed to 2.
`timescale 1ns / 1ps
module wind_triangle_heading (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        wind_speed,
  input  logic [15:0]        airspeed,
  input  logic [15:0]        wind_dir,
  input  logic [15:0]        current_course,
  input  logic [15:0]        target_course,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        target_heading,
  output logic signed [17:0] target_ground_speed,
  output logic [15:0]        current_heading,
  output logic signed [15:0] heading_diff,
  output logic [1:0]         target_status,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  localparam int LAT = wth_pkg::LAT;

  logic [15:0]          min_airspeed;
  logic [LAT-1:0]       vld;
  logic                 en;
  logic                 low;
  wth_pkg::status_t     t_status;
  wth_pkg::status_t     c_status;
  logic signed [17:0]   c_gs;

  assign en = out_ready || !vld[LAT-1];
  assign in_ready = en;
  assign out_valid = vld[LAT-1];
  assign low = airspeed <= min_airspeed;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_airspeed <= 16'd2;
    end else if (cfg_we) begin
      min_airspeed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  wth_course u_target (
    .clk    (clk),
    .en     (en),
    .w      (wind_speed),
    .a      (airspeed),
    .wd     (wind_dir),
    .crs    (target_course),
    .low    (low),
    .hd     (target_heading),
    .gs     (target_ground_speed),
    .status (t_status)
  );

  wth_course u_current (
    .clk    (clk),
    .en     (en),
    .w      (wind_speed),
    .a      (airspeed),
    .wd     (wind_dir),
    .crs    (current_course),
    .low    (low),
    .hd     (current_heading),
    .gs     (c_gs),
    .status (c_status)
  );

  assign target_status = t_status;
  assign heading_diff = $signed(target_heading - current_heading);
endmodule

// ----- src/wth_checker.sv -----
// Port-level checker for the wind triangle solver, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wth_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        target_heading,
  input logic signed [17:0] target_ground_speed,
  input logic [15:0]        current_heading,
  input logic signed [15:0] heading_diff,
  input logic [1:0]         target_status
);
  logic is_low;
  logic is_kite;
  logic low_zero;

  assign is_low = out_valid && target_status == wth_pkg::ST_LOW;
  assign is_kite = out_valid && target_status == wth_pkg::ST_KITE;
  assign low_zero = target_heading == 16'd0 && current_heading == 16'd0 &&
                    target_ground_speed == 18'sd0;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_IMPL(a_status_code, clk, rst, out_valid, target_status <= wth_pkg::ST_LOW, "bad status")
  `ASSERT_IMPL(a_low_zero, clk, rst, is_low, low_zero, "low airspeed result not zero")
  `ASSERT_IMPL(a_kite_zero, clk, rst, is_kite, target_ground_speed == 18'sd0, "kite speed not zero")
  `ASSERT_IMPL(a_diff, clk, rst, out_valid, heading_diff == $signed(target_heading - current_heading), "bad diff")
endmodule

bind wind_triangle_heading wth_checker u_wth_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .target_heading      (target_heading),
  .target_ground_speed (target_ground_speed),
  .current_heading     (current_heading),
  .heading_diff        (heading_diff),
  .target_status       (target_status)
);
